// ===== hw/rtl/cnc_pkg.sv =====
`timescale 1ns / 1ps
// cnc_pkg: shared field widths, operation codes and the merge step record
// for the common neighbor counter; no dependencies
package cnc_pkg;

  // payload field widths
  localparam int OP_W    = 2;
  localparam int ADDR_W  = 13;
  localparam int VALUE_W = 14;
  localparam int NODE_W  = 10;
  localparam int COUNT_W = 14;

  // operation codes
  localparam logic [OP_W-1:0] OP_WR_OFS  = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_EDGE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // one decision of the two-pointer merge
  typedef struct packed {
    logic live;   // both lists still have entries
    logic match;  // heads are equal
    logic adv_a;  // step list a
    logic adv_b;  // step list b
  } merge_step_t;

endpackage

// ===== hw/rtl/cnc_in_if.sv =====
`timescale 1ns / 1ps
// cnc_in_if: input channel of the common neighbor counter (valid/ready plus payload)
// depends on cnc_pkg
interface cnc_in_if import cnc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [ADDR_W-1:0]  address;
  logic [VALUE_W-1:0] value;
  logic [NODE_W-1:0]  node_a;
  logic [NODE_W-1:0]  node_b;

  modport source (output valid, operation, address, value, node_a, node_b, input ready);
  modport sink   (input valid, operation, address, value, node_a, node_b, output ready);
endinterface

// ===== hw/rtl/cnc_out_if.sv =====
`timescale 1ns / 1ps
// cnc_out_if: result channel of the common neighbor counter (valid/ready plus count)
// depends on cnc_pkg
interface cnc_out_if import cnc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] common_count;

  modport source (output valid, common_count, input ready);
  modport sink   (input valid, common_count, output ready);
endinterface

// ===== hw/rtl/csr_common_neighbor_count_top.sv =====
`timescale 1ns / 1ps
// csr_common_neighbor_count_top: sequencer, offset table and edge store of the counter
// depends on cnc_pkg, cnc_in_if, cnc_out_if, cnc_ram, cnc_merge_unit

// Holds a graph in compressed sparse row form and counts the common neighbors of two
// nodes. Offset writes and edge writes give no result. A query transaction reads both
// list bounds from the offset table (list starts, then list ends, both nodes at once on
// the table's two read ports), then merges the two sorted lists one step per cycle out
// of the dual-read edge store; it takes S <= deg(a) + deg(b) merge steps. in_ready is
// low after the accept until the query has moved its count into the output register.
// The count sits in an output register, so load transactions may proceed while it
// waits to be taken; a later query finishing before that waits in its last step.
// Neither memory is cleared after reset: entries must be written before a query reads
// them.
module csr_common_neighbor_count_top import cnc_pkg::*; #(
  parameter int NODE_COUNT = 1024,
  parameter int EDGE_COUNT = 8192
) (
  input logic       clk,
  input logic       rst_n,
  cnc_in_if.sink    in_ch,
  cnc_out_if.source out_ch
);

  localparam int OFS_DEPTH = NODE_COUNT + 1;
  localparam int OFS_AW    = $clog2(OFS_DEPTH);
  localparam int EDGE_AW   = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
  localparam int PTR_W     = $clog2(EDGE_COUNT + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_OFS_LO = 2'd1;
  localparam logic [1:0] ST_OFS_HI = 2'd2;
  localparam logic [1:0] ST_MERGE  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [NODE_W-1:0]  node_a_r, node_a_nxt;
  logic [NODE_W-1:0]  node_b_r, node_b_nxt;
  logic [PTR_W-1:0]   ptr_a_r, ptr_a_nxt;
  logic [PTR_W-1:0]   ptr_b_r, ptr_b_nxt;
  logic [PTR_W-1:0]   end_a_r, end_a_nxt;
  logic [PTR_W-1:0]   end_b_r, end_b_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               in_accept;
  logic [31:0]        addr_ext;
  logic [31:0]        in_node_a_ext, in_node_b_ext;
  logic [31:0]        node_a_inc, node_b_inc;
  logic               node_oor;
  logic               ofs_we, edge_we;
  logic [OFS_AW-1:0]  ofs_ra_a, ofs_ra_b;
  logic [VALUE_W-1:0] ofs_rd_a, ofs_rd_b;
  logic [NODE_W-1:0]  edge_rd_a, edge_rd_b;
  merge_step_t        step;

  // clamp a stored offset to the end of the edge store
  function automatic logic [PTR_W-1:0] sat_edge(input logic [VALUE_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(EDGE_COUNT)) begin
      w = 32'(EDGE_COUNT);
    end
    return w[PTR_W-1:0];
  endfunction

  assign in_accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready   = (state_r == ST_IDLE);
  assign addr_ext      = 32'(in_ch.address);
  assign in_node_a_ext = 32'(in_ch.node_a);
  assign in_node_b_ext = 32'(in_ch.node_b);
  assign node_a_inc    = 32'(node_a_r) + 32'd1;
  assign node_b_inc    = 32'(node_b_r) + 32'd1;
  assign node_oor      = (32'(node_a_r) >= 32'(NODE_COUNT)) ||
                         (32'(node_b_r) >= 32'(NODE_COUNT));

  // load transactions write straight through
  assign ofs_we  = in_accept && (in_ch.operation == OP_WR_OFS) &&
                   (addr_ext <= 32'(NODE_COUNT));
  assign edge_we = in_accept && (in_ch.operation == OP_WR_EDGE) &&
                   (addr_ext < 32'(EDGE_COUNT));

  // offset table read: list starts at accept, list ends in the cycle after
  always_comb begin
    if (state_r == ST_IDLE) begin
      ofs_ra_a = in_node_a_ext[OFS_AW-1:0];
      ofs_ra_b = in_node_b_ext[OFS_AW-1:0];
    end else begin
      ofs_ra_a = node_a_inc[OFS_AW-1:0];
      ofs_ra_b = node_b_inc[OFS_AW-1:0];
    end
  end

  cnc_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (OFS_DEPTH)
  ) u_ofs_ram (
    .clk     (clk),
    .we      (ofs_we),
    .waddr   (addr_ext[OFS_AW-1:0]),
    .wdata   (in_ch.value),
    .raddr_a (ofs_ra_a),
    .rdata_a (ofs_rd_a),
    .raddr_b (ofs_ra_b),
    .rdata_b (ofs_rd_b)
  );

  // edge store is read at the next pointers so heads line up with ptr_*_r
  cnc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (EDGE_COUNT)
  ) u_edge_ram (
    .clk     (clk),
    .we      (edge_we),
    .waddr   (addr_ext[EDGE_AW-1:0]),
    .wdata   (in_ch.value[NODE_W-1:0]),
    .raddr_a (ptr_a_nxt[EDGE_AW-1:0]),
    .rdata_a (edge_rd_a),
    .raddr_b (ptr_b_nxt[EDGE_AW-1:0]),
    .rdata_b (edge_rd_b)
  );

  cnc_merge_unit #(
    .PTR_W (PTR_W)
  ) u_merge (
    .ptr_a (ptr_a_r),
    .ptr_b (ptr_b_r),
    .end_a (end_a_r),
    .end_b (end_b_r),
    .id_a  (edge_rd_a),
    .id_b  (edge_rd_b),
    .step  (step)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    node_a_nxt    = node_a_r;
    node_b_nxt    = node_b_r;
    ptr_a_nxt     = ptr_a_r;
    ptr_b_nxt     = ptr_b_r;
    end_a_nxt     = end_a_r;
    end_b_nxt     = end_b_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_count_nxt = out_count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_ch.operation == OP_QUERY)) begin
          node_a_nxt = in_ch.node_a;
          node_b_nxt = in_ch.node_b;
          state_nxt  = ST_OFS_LO;
        end
      end
      ST_OFS_LO: begin
        ptr_a_nxt = sat_edge(ofs_rd_a);
        ptr_b_nxt = sat_edge(ofs_rd_b);
        state_nxt = ST_OFS_HI;
      end
      ST_OFS_HI: begin
        // an out-of-range node gives an empty list
        end_a_nxt = node_oor ? '0 : sat_edge(ofs_rd_a);
        end_b_nxt = node_oor ? '0 : sat_edge(ofs_rd_b);
        count_nxt = '0;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (step.live) begin
          ptr_a_nxt = ptr_a_r + PTR_W'(step.adv_a);
          ptr_b_nxt = ptr_b_r + PTR_W'(step.adv_b);
          count_nxt = count_r + COUNT_W'(step.match);
        end else if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    node_a_r    <= node_a_nxt;
    node_b_r    <= node_b_nxt;
    ptr_a_r     <= ptr_a_nxt;
    ptr_b_r     <= ptr_b_nxt;
    end_a_r     <= end_a_nxt;
    end_b_r     <= end_b_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.common_count = out_count_r;

  // a query walks both bound reads before merging
  a_query_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_ch.operation == OP_QUERY)
      |=> (state_r == ST_OFS_LO) ##1 (state_r == ST_OFS_HI) ##1 (state_r == ST_MERGE))
    else $error("query did not follow the bound read sequence");

  // load transactions never start the sequencer
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_ch.operation != OP_QUERY) |=> (state_r == ST_IDLE))
    else $error("load transaction left the idle state");

  // a result only appears at the end of a merge
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_MERGE) && !$past(step.live))
    else $error("result raised outside the end of a merge");

endmodule

// ===== hw/rtl/cnc_ram.sv =====
`timescale 1ns / 1ps
// cnc_ram: generic memory, one write port and two registered read ports
// no dependencies
module cnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/cnc_merge_unit.sv =====
`timescale 1ns / 1ps
// cnc_merge_unit: compare unit for one step of the two-pointer list merge
// depends on cnc_pkg
module cnc_merge_unit import cnc_pkg::*; #(
  parameter int PTR_W = 14
) (
  input  logic [PTR_W-1:0]  ptr_a,
  input  logic [PTR_W-1:0]  ptr_b,
  input  logic [PTR_W-1:0]  end_a,
  input  logic [PTR_W-1:0]  end_b,
  input  logic [NODE_W-1:0] id_a,
  input  logic [NODE_W-1:0] id_b,
  output merge_step_t       step
);

  // advance the smaller head, both on a match
  always_comb begin
    step.live  = (ptr_a < end_a) && (ptr_b < end_b);
    step.match = step.live && (id_a == id_b);
    step.adv_a = step.live && (id_a <= id_b);
    step.adv_b = step.live && (id_a >= id_b);
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for csr_common_neighbor_count_top, loads small csr graphs
// and checks every common neighbor count against a scripted count or an in-bench merge predictor
// depends on cnc_pkg, cnc_in_if, cnc_out_if and the counter rtl
module tb_top;
  import cnc_pkg::*;

  localparam int NODE_COUNT = 1024;
  localparam int EDGE_COUNT = 8192;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 345;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one row of the directed script; known < 0 means the predictor decides
  typedef struct {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic [NODE_W-1:0]  na;
    logic [NODE_W-1:0]  nb;
    int                 known;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cnc_in_if  in_ch();
  cnc_out_if out_ch();

  csr_common_neighbor_count_top #(
    .NODE_COUNT(NODE_COUNT),
    .EDGE_COUNT(EDGE_COUNT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // predictor copy of the graph, updated on accepted transactions
  logic [VALUE_W-1:0] shadow_ofs  [0:NODE_COUNT];
  logic [NODE_W-1:0]  shadow_edge [0:EDGE_COUNT-1];
  logic [COUNT_W-1:0] pending_counts [$];
  int                 table_counts [$];

  // what the stimulus has written so far, used to keep queries on written entries
  logic [VALUE_W-1:0] plan_ofs      [0:NODE_COUNT];
  bit                 plan_ofs_set  [0:NODE_COUNT];
  bit                 plan_edge_set [0:EDGE_COUNT-1];
  int                 recent_nodes [$];
  script_row_t        script [$];

  int items_sent = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic int clamp_to_store(logic [VALUE_W-1:0] x);
    return (x > EDGE_COUNT) ? EDGE_COUNT : int'(x);
  endfunction

  // two-pointer merge over the shadow graph
  function automatic logic [COUNT_W-1:0] count_common_neighbors(int na, int nb);
    int i, a_end, j, b_end, hits;
    if (na >= NODE_COUNT || nb >= NODE_COUNT) return '0;
    i = clamp_to_store(shadow_ofs[na]);
    a_end = clamp_to_store(shadow_ofs[na + 1]);
    j = clamp_to_store(shadow_ofs[nb]);
    b_end = clamp_to_store(shadow_ofs[nb + 1]);
    hits = 0;
    while (i < a_end && j < b_end) begin
      if (shadow_edge[i] == shadow_edge[j]) begin
        i++;
        j++;
        hits++;
      end else if (shadow_edge[i] < shadow_edge[j]) begin
        i++;
      end else begin
        j++;
      end
    end
    return COUNT_W'(hits);
  endfunction

  task automatic apply_transaction(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                   logic [VALUE_W-1:0] value, logic [NODE_W-1:0] na,
                                   logic [NODE_W-1:0] nb);
    int known;
    case (op)
      OP_WR_OFS: if (addr <= NODE_COUNT) shadow_ofs[addr] = value;
      OP_WR_EDGE: if (addr < EDGE_COUNT) shadow_edge[addr] = value[NODE_W-1:0];
      OP_QUERY: begin
        known = table_counts.pop_front();
        pending_counts.insert(pending_counts.size(),
                              known >= 0 ? COUNT_W'(known)
                                         : count_common_neighbors(na, nb));
      end
      default: ;
    endcase
  endtask

  // result check first, then predict from the accepted input transaction
  always @(posedge clk) begin : scoreboard
    logic [COUNT_W-1:0] want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_counts.size() == 0) begin
        $error("common_count: expected none, actual %0d", out_ch.common_count);
        fail_count++;
      end else begin
        want = pending_counts.pop_front();
        if (out_ch.common_count !== want) begin
          $error("common_count: expected %0d, actual %0d", want, out_ch.common_count);
          fail_count++;
        end
      end
    end
    if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      apply_transaction(in_ch.operation, in_ch.address, in_ch.value,
                        in_ch.node_a, in_ch.node_b);
  end

  // a node may be queried once its bounds and every edge in its list are written
  function automatic bit node_ready(int n);
    int s, e;
    if (!plan_ofs_set[n] || !plan_ofs_set[n + 1]) return 1'b0;
    s = clamp_to_store(plan_ofs[n]);
    e = clamp_to_store(plan_ofs[n + 1]);
    for (int k = s; k < e; k++)
      if (!plan_edge_set[k]) return 1'b0;
    return 1'b1;
  endfunction

  // drive one transaction, with random idle cycles ahead of it
  task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                           logic [VALUE_W-1:0] value, logic [NODE_W-1:0] na,
                           logic [NODE_W-1:0] nb, int known);
    items_sent++;
    if (op == OP_WR_OFS && addr <= NODE_COUNT) begin
      plan_ofs[addr] = value;
      plan_ofs_set[addr] = 1'b1;
    end else if (op == OP_WR_EDGE && addr < EDGE_COUNT) begin
      plan_edge_set[addr] = 1'b1;
    end else if (op == OP_QUERY) begin
      table_counts.insert(table_counts.size(), known);
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.address   <= addr;
    in_ch.value     <= value;
    in_ch.node_a    <= na;
    in_ch.node_b    <= nb;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_query(int a, int b);
    send_item(OP_QUERY, ADDR_W'($urandom), VALUE_W'($urandom), NODE_W'(a), NODE_W'(b), -1);
  endtask

  task automatic add_row(logic [OP_W-1:0] op, int addr, int value, int na, int nb,
                         int known);
    script_row_t r;
    r.op = op;
    r.addr = ADDR_W'(addr);
    r.value = VALUE_W'(value);
    r.na = NODE_W'(na);
    r.nb = NODE_W'(nb);
    r.known = known;
    script.insert(script.size(), r);
  endtask

  task automatic load_edges(int ids[$], int e0, int skip);
    logic [VALUE_W-1:0] v;
    for (int k = 0; k < ids.size(); k++) begin
      if (k == skip) continue;
      // sometimes set bits above the node id; only the low bits are kept
      v = VALUE_W'(ids[k]);
      if ($urandom_range(0, 3) == 0) v[VALUE_W-1:NODE_W] = 4'($urandom_range(1, 15));
      send_item(OP_WR_EDGE, ADDR_W'(e0 + k), v, NODE_W'($urandom), NODE_W'($urandom), -1);
    end
  endtask

  // write a run of consecutive nodes with overlapping sorted lists, then query them
  task automatic build_block();
    int k, n0, e0, total, r0, id, deg, sa, sb, tmp, skip, start;
    bit tail, edges_first;
    int ids [$];
    int cnt [$];
    logic [VALUE_W-1:0] ofs_value;
    k = $urandom_range(1, 6);
    n0 = $urandom_range(0, NODE_COUNT - k);
    r0 = $urandom_range(0, NODE_COUNT - 1);
    for (int m = 0; m < k; m++) begin
      deg = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 100) : $urandom_range(0, 10);
      id = r0 + $urandom_range(0, 3);
      cnt.insert(cnt.size(), 0);
      for (int d = 0; d < deg && id < NODE_COUNT; d++) begin
        ids.insert(ids.size(), id);
        cnt[m]++;
        id += $urandom_range(1, 3);
      end
    end
    total = ids.size();
    // occasional unsorted list
    if (total >= 2 && $urandom_range(0, 19) == 0) begin
      sa = $urandom_range(0, total - 1);
      sb = $urandom_range(0, total - 1);
      tmp = ids[sa];
      ids[sa] = ids[sb];
      ids[sb] = tmp;
    end
    // some blocks end at the top of the store with a saturating last offset
    tail = ($urandom_range(0, 7) == 0);
    e0 = tail ? EDGE_COUNT - total : $urandom_range(0, EDGE_COUNT - total);
    // broken sequence: one edge write left out
    skip = ($urandom_range(0, 9) == 0 && total > 0) ? $urandom_range(0, total - 1) : -1;
    edges_first = $urandom_range(0, 1);
    if (edges_first) load_edges(ids, e0, skip);
    start = e0;
    for (int m = 0; m <= k; m++) begin
      ofs_value = VALUE_W'(start);
      if (m == k && tail) ofs_value = VALUE_W'($urandom_range(EDGE_COUNT, 2**VALUE_W - 1));
      send_item(OP_WR_OFS, ADDR_W'(n0 + m), ofs_value, NODE_W'($urandom),
                NODE_W'($urandom), -1);
      if (m < k) start += cnt[m];
    end
    if (!edges_first) load_edges(ids, e0, skip);
    for (int m = 0; m < k; m++) recent_nodes.insert(recent_nodes.size(), n0 + m);
    while (recent_nodes.size() > 48) void'(recent_nodes.pop_front());
    repeat ($urandom_range(1, 4)) begin
      sa = n0 + $urandom_range(0, k - 1);
      sb = n0 + $urandom_range(0, k - 1);
      if (node_ready(sa) && node_ready(sb)) send_query(sa, sb);
    end
  endtask

  function automatic int pick_node();
    if (recent_nodes.size() > 0 && $urandom_range(0, 4) != 0)
      return recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
    return $urandom_range(0, NODE_COUNT - 1);
  endfunction

  task automatic issue_query();
    int a, b;
    for (int t = 0; t < 20; t++) begin
      a = pick_node();
      b = pick_node();
      if (node_ready(a) && node_ready(b)) begin
        send_query(a, b);
        return;
      end
    end
  endtask

  // unused opcode, ignored offset writes and stray overwrites
  task automatic make_noise();
    case ($urandom_range(0, 3))
      0: send_item(OP_UNUSED, ADDR_W'($urandom), VALUE_W'($urandom), NODE_W'($urandom),
                   NODE_W'($urandom), -1);
      1: send_item(OP_WR_OFS, ADDR_W'($urandom_range(NODE_COUNT + 1, 2**ADDR_W - 1)),
                   VALUE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom), -1);
      2: send_item(OP_WR_EDGE, ADDR_W'($urandom), VALUE_W'($urandom), NODE_W'($urandom),
                   NODE_W'($urandom), -1);
      default: send_item(OP_WR_OFS, ADDR_W'($urandom_range(0, NODE_COUNT)),
                         VALUE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom), -1);
    endcase
  endtask

  // hold the sender off until every expected count has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  initial begin
    int goal;
    int pick;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_WR_OFS;
    in_ch.address   <= '0;
    in_ch.value     <= '0;
    in_ch.node_a    <= '0;
    in_ch.node_b    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // small graph: node 0 {5,9,1023}, node 1 {5,7,1023}, node 2 empty
    add_row(OP_WR_OFS, 0, 0, 0, 0, -1);
    add_row(OP_WR_OFS, 1, 3, 0, 0, -1);
    add_row(OP_WR_OFS, 2, 6, 0, 0, -1);
    add_row(OP_WR_OFS, 3, 6, 0, 0, -1);
    add_row(OP_WR_EDGE, 0, 5, 0, 0, -1);
    add_row(OP_WR_EDGE, 1, 9, 0, 0, -1);
    add_row(OP_WR_EDGE, 2, 16383, 0, 0, -1);
    add_row(OP_WR_EDGE, 3, 5, 0, 0, -1);
    add_row(OP_WR_EDGE, 4, 7, 0, 0, -1);
    add_row(OP_WR_EDGE, 5, 1023, 0, 0, -1);
    add_row(OP_QUERY, 0, 0, 0, 1, 2);
    add_row(OP_QUERY, 8191, 16383, 0, 0, 3);
    add_row(OP_QUERY, 0, 0, 0, 2, 0);
    // last node at the top of the store, end offset saturates
    add_row(OP_WR_OFS, 1023, 8190, 0, 0, -1);
    add_row(OP_WR_OFS, 1024, 16383, 1023, 1023, -1);
    add_row(OP_WR_EDGE, 8190, 5, 0, 0, -1);
    add_row(OP_WR_EDGE, 8191, 1023, 0, 0, -1);
    add_row(OP_QUERY, 0, 0, 1023, 0, 2);
    // ignored offset write and unused opcode leave the graph alone
    add_row(OP_WR_OFS, 1025, 0, 0, 0, -1);
    add_row(OP_UNUSED, 8191, 16383, 1023, 1023, -1);
    add_row(OP_QUERY, 0, 0, 1023, 1023, 2);
    // start above end gives an empty list
    add_row(OP_WR_OFS, 4, 2, 0, 0, -1);
    add_row(OP_QUERY, 0, 0, 3, 0, 0);
    // unsorted list: merge runs on what is stored
    add_row(OP_WR_EDGE, 2, 4, 0, 0, -1);
    add_row(OP_QUERY, 0, 0, 0, 1, -1);
    // both bounds past the store
    add_row(OP_WR_OFS, 1023, 9000, 0, 0, -1);
    add_row(OP_QUERY, 0, 0, 1023, 1, 0);

    @(posedge clk);
    foreach (script[r])
      send_item(script[r].op, script[r].addr, script[r].value, script[r].na,
                script[r].nb, script[r].known);
    drain();

    // random phases: no idling, sender idle, receiver stalling, both
    goal = items_sent;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1) ? 87 : (p == 3) ? 20 : 0;
      recv_stall_pct = (p == 2) ? 87 : (p == 3) ? 20 : 0;
      goal += PHASE_ITEMS;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) build_block();
        else if (pick < 85) issue_query();
        else make_noise();
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== csr_common_neighbor_count_top.f =====
hw/rtl/cnc_pkg.sv
hw/rtl/cnc_in_if.sv
hw/rtl/cnc_out_if.sv
hw/rtl/cnc_ram.sv
hw/rtl/cnc_merge_unit.sv
hw/rtl/csr_common_neighbor_count_top.sv
test/tb_top.sv
